FILE: sv/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared constants, types and saturation helpers of the biquad cascade:
// formats of samples, coefficients and states, register indexes.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int SECTIONS  = 3;
    localparam int MAX_SECS  = 3;
    localparam int SAMP_W    = 24;
    localparam int TDATA_W   = ((SAMP_W + 7) / 8) * 8;

    localparam int COEF_W    = 20;
    localparam int DEN_W     = 24;
    localparam int STATE_W   = 48;
    localparam int FRAC_W    = 21;
    localparam int B_ALIGN   = 4;

    localparam int MB_W      = COEF_W + SAMP_W;
    localparam int BX_W      = MB_W + B_ALIGN;
    localparam int AY_W      = DEN_W + SAMP_W;
    localparam int MAX_W     = (BX_W > STATE_W) ? BX_W : STATE_W;
    localparam int SUM_W     = ((MAX_W > AY_W) ? MAX_W : AY_W) + 2;
    localparam int SH_W      = SUM_W - FRAC_W;

    localparam int NUM_REG_W = 3 * COEF_W;
    localparam int DEN_REG_W = 2 * DEN_W;
    localparam int PRM_REG_W = 3 * COEF_W;
    localparam int CFG_W     = NUM_REG_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SEC0_NUM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEC0_DEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEC1_NUM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEC1_DEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEC2_NUM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEC2_DEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_HI = 3'd7;

    localparam logic [NUM_REG_W-1:0] NUM_RESET = NUM_REG_W'(1 << (COEF_W - 3));

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1 << (FRAC_W - 1));

    localparam logic signed [SUM_W-1:0] ST_HI =
        {{(SUM_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ST_LO =
        {{(SUM_W - STATE_W + 1){1'b1}}, {(STATE_W - 1){1'b0}}};
    localparam logic signed [SH_W-1:0] SMP_HI =
        {{(SH_W - SAMP_W + 1){1'b0}}, {(SAMP_W - 1){1'b1}}};
    localparam logic signed [SH_W-1:0] SMP_LO =
        {{(SH_W - SAMP_W + 1){1'b1}}, {(SAMP_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [SAMP_W-1:0] x;
        logic signed [SAMP_W-1:0] xs;
        logic                     prime;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [DEN_W-1:0]  a1;
        logic signed [DEN_W-1:0]  a2;
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
    } t_coef;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > ST_HI) begin
            r = {1'b0, {(STATE_W - 1){1'b1}}};
        end else if (v < ST_LO) begin
            r = {1'b1, {(STATE_W - 1){1'b0}}};
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMP_W-1:0] sat_samp(input logic signed [SH_W-1:0] v);
        logic signed [SAMP_W-1:0] r;
        if (v > SMP_HI) begin
            r = {1'b0, {(SAMP_W - 1){1'b1}}};
        end else if (v < SMP_LO) begin
            r = {1'b1, {(SAMP_W - 1){1'b0}}};
        end else begin
            r = v[SAMP_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/biquad_cascade_iir_filter_top.sv
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_top
// Cascade of second-order IIR sections, one cell per section.
//
// Samples enter on the s_axis channel (tdata: sample, tuser: prime,
// tlast: block end) and leave on m_axis (tdata: filtered sample, tlast:
// copy of the input tlast), one result per item, in order.
// Each cell works on an item in four steps: products of the sample, the
// rounded section output, the feedback products, then the state update.
// A cell hands its output on as soon as the rounded section output is
// registered, so an item passes each cell in turn and then the output
// register. A cell takes no new item until it has finished the state
// update of the last one and its output has been taken. The cfg channel
// writes one register per cycle and is always ready; write only while
// the filter is idle. Reset makes every section a pass-through (b0 one,
// all else zero) and clears all states. When m_axis stalls, the output
// register holds its item, the last cell keeps its output and the chain
// fills up behind it until s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cfg write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bqc_pkg::CFG_W-1:0]         i_cfg_data,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bqc_pkg::TDATA_W-1:0]       s_axis_tdata,   // sample
    input  logic                              s_axis_tuser,   // prime
    input  logic                              s_axis_tlast,   // sample_last
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bqc_pkg::TDATA_W-1:0]       m_axis_tdata,   // filtered
    output logic                              m_axis_tlast    // result_last
);
    import bqc_pkg::*;

    logic [NUM_REG_W-1:0]            r_num [MAX_SECS];
    logic [DEN_REG_W-1:0]            r_den [MAX_SECS];
    logic [PRM_REG_W-1:0]            r_plo;
    logic [PRM_REG_W-1:0]            r_phi;
    logic [2*PRM_REG_W-1:0]          w_kflat;

    t_item                           w_item  [SECTIONS+1];
    logic                            w_valid [SECTIONS+1];
    logic                            w_ready [SECTIONS+1];

    logic                            r_mvalid;
    logic [SAMP_W-1:0]               r_mdata;
    logic                            r_mlast;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SECS; s++) begin
                r_num[s] <= NUM_RESET;
                r_den[s] <= '0;
            end
            r_plo <= '0;
            r_phi <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SEC0_NUM: r_num[0] <= i_cfg_data[NUM_REG_W-1:0];
                REG_SEC0_DEN: r_den[0] <= i_cfg_data[DEN_REG_W-1:0];
                REG_SEC1_NUM: r_num[1] <= i_cfg_data[NUM_REG_W-1:0];
                REG_SEC1_DEN: r_den[1] <= i_cfg_data[DEN_REG_W-1:0];
                REG_SEC2_NUM: r_num[2] <= i_cfg_data[NUM_REG_W-1:0];
                REG_SEC2_DEN: r_den[2] <= i_cfg_data[DEN_REG_W-1:0];
                REG_PRIME_LO: r_plo    <= i_cfg_data[PRM_REG_W-1:0];
                REG_PRIME_HI: r_phi    <= i_cfg_data[PRM_REG_W-1:0];
                default:      r_plo    <= r_plo;
            endcase
        end
    end

    // steady-state values, state 2s is z1 and 2s+1 is z2 of section s
    assign w_kflat = {r_phi, r_plo};

    assign w_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = w_ready[0];
    assign w_item[0].x     = s_axis_tdata[SAMP_W-1:0];
    assign w_item[0].xs    = s_axis_tdata[SAMP_W-1:0];
    assign w_item[0].prime = s_axis_tuser;
    assign w_item[0].last  = s_axis_tlast;

    for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
        t_coef w_coef;

        assign w_coef.b0 = r_num[s][0*COEF_W +: COEF_W];
        assign w_coef.b1 = r_num[s][1*COEF_W +: COEF_W];
        assign w_coef.b2 = r_num[s][2*COEF_W +: COEF_W];
        assign w_coef.a1 = r_den[s][0*DEN_W +: DEN_W];
        assign w_coef.a2 = r_den[s][1*DEN_W +: DEN_W];
        assign w_coef.k1 = w_kflat[(2*s)*COEF_W +: COEF_W];
        assign w_coef.k2 = w_kflat[(2*s+1)*COEF_W +: COEF_W];

        bqc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (w_coef),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_item  (w_item[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_item  (w_item[s+1])
        );
    end

    // output register
    assign w_ready[SECTIONS] = !r_mvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_valid[SECTIONS] && w_ready[SECTIONS]) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_valid[SECTIONS] && w_ready[SECTIONS]) begin
            r_mdata <= w_item[SECTIONS].x;
            r_mlast <= w_item[SECTIONS].last;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = TDATA_W'(r_mdata);
    assign m_axis_tlast  = r_mlast;

endmodule

FILE: sv/bqc_cell.sv
// ----------------------------------------------------------------------------
// bqc_cell
// One second-order section in transposed direct form II. Holds its two
// states, takes an item from its left neighbor and hands the section
// output to its right neighbor, one item at a time in four steps.
// ----------------------------------------------------------------------------
module bqc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bqc_pkg::t_coef i_coef,
    input  logic           i_valid,
    output logic           o_ready,
    input  bqc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output bqc_pkg::t_item o_item
);
    import bqc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_FB   = 4'b0100,
        ST_UPD  = 4'b1000
    } t_phase;

    t_phase                     r_state;
    t_phase                     n_state;
    logic                       r_ovalid;
    logic signed [STATE_W-1:0]  r_z1;
    logic signed [STATE_W-1:0]  r_z2;
    logic signed [BX_W-1:0]     r_p0;
    logic signed [BX_W-1:0]     r_p1;
    logic signed [BX_W-1:0]     r_p2;
    logic signed [STATE_W-1:0]  r_pk1;
    logic signed [STATE_W-1:0]  r_pk2;
    logic signed [AY_W-1:0]     r_q1;
    logic signed [AY_W-1:0]     r_q2;
    t_item                      r_item;

    logic                       w_take;
    logic signed [SAMP_W-1:0]   w_x;
    logic signed [SAMP_W-1:0]   w_xs;
    logic signed [SAMP_W-1:0]   w_y;
    logic signed [MB_W-1:0]     w_m0;
    logic signed [MB_W-1:0]     w_m1;
    logic signed [MB_W-1:0]     w_m2;
    logic signed [MB_W-1:0]     w_mk1;
    logic signed [MB_W-1:0]     w_mk2;
    logic signed [BX_W-1:0]     w_pk1;
    logic signed [BX_W-1:0]     w_pk2;
    logic signed [AY_W-1:0]     w_q1;
    logic signed [AY_W-1:0]     w_q2;
    logic signed [STATE_W-1:0]  w_zeff;
    logic signed [SUM_W-1:0]    w_acc;
    logic signed [SAMP_W-1:0]   w_ynew;
    logic signed [SUM_W-1:0]    w_s1;
    logic signed [SUM_W-1:0]    w_s2;

    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_item  = r_item;

    // products of the incoming sample
    assign w_x   = i_item.x;
    assign w_xs  = i_item.xs;
    assign w_m0  = i_coef.b0 * w_x;
    assign w_m1  = i_coef.b1 * w_x;
    assign w_m2  = i_coef.b2 * w_x;
    assign w_mk1 = i_coef.k1 * w_xs;
    assign w_mk2 = i_coef.k2 * w_xs;
    assign w_pk1 = {w_mk1, {B_ALIGN{1'b0}}};
    assign w_pk2 = {w_mk2, {B_ALIGN{1'b0}}};

    // section output, rounded half up and saturated
    assign w_zeff = r_item.prime ? r_pk1 : r_z1;
    assign w_acc  = SUM_W'(r_p0) + SUM_W'(w_zeff) + RND_HALF;
    assign w_ynew = sat_samp(w_acc[SUM_W-1:FRAC_W]);

    // feedback products
    assign w_y  = r_item.x;
    assign w_q1 = i_coef.a1 * w_y;
    assign w_q2 = i_coef.a2 * w_y;

    // state update
    assign w_s1 = SUM_W'(r_p1) - SUM_W'(r_q1) + SUM_W'(r_z2);
    assign w_s2 = SUM_W'(r_p2) - SUM_W'(r_q2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_take) n_state = ST_ACC;
            ST_ACC:  n_state = ST_FB;
            ST_FB:   n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_z1     <= '0;
            r_z2     <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_ACC) begin
                r_ovalid <= 1'b1;
                if (r_item.prime) begin
                    r_z2 <= r_pk2;
                end
            end
            if (r_state == ST_UPD) begin
                r_z1 <= sat_state(w_s1);
                r_z2 <= sat_state(w_s2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
            r_p0   <= {w_m0, {B_ALIGN{1'b0}}};
            r_p1   <= {w_m1, {B_ALIGN{1'b0}}};
            r_p2   <= {w_m2, {B_ALIGN{1'b0}}};
            r_pk1  <= sat_state(SUM_W'(w_pk1));
            r_pk2  <= sat_state(SUM_W'(w_pk2));
        end
        if (r_state == ST_ACC) begin
            r_item.x <= w_ynew;
        end
        if (r_state == ST_FB) begin
            r_q1 <= w_q1;
            r_q2 <= w_q2;
        end
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-section biquad cascade. A directed table
// covers pass-through after reset, rounding, saturation, priming and block
// ends; random framed streams then run under several coefficient sets and
// idle patterns, with one long output stall. Every result item is compared
// with its row's table result or a bit-exact cascade model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bqc_pkg::*;

    localparam int     HALF_PERIOD  = 10;
    localparam int     RESET_CYCLES = 11;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     PHASE_ITEMS  = 225;
    localparam int     PHASES       = 8;
    localparam int     PAD_W        = CFG_W - DEN_REG_W;
    localparam int     ONE_Q17      = 1 << 17;
    localparam int     ONE_Q21      = 1 << 21;
    localparam longint STATE_MAX    = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN    = -STATE_MAX - 1;
    localparam longint SMP_MAX      = (longint'(1) <<< (SAMP_W - 1)) - 1;
    localparam longint SMP_MIN      = -SMP_MAX - 1;

    typedef enum logic [1:0] {TUNE_STABLE, TUNE_NOISE, TUNE_ZERO, TUNE_ONES} t_tune_kind;

    typedef struct packed {
        logic signed [SAMP_W-1:0] smp;
        logic                     prm;
        logic                     lst;
        logic                     typed;
        logic signed [SAMP_W-1:0] res;
    } t_stim_row;

    typedef struct packed {
        logic signed [SAMP_W-1:0] filtered;
        logic                     last;
    } t_filt_out;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   m_axis_tlast;

    logic [CFG_W-1:0]       model_reg [8];
    longint                 delay [2 * MAX_SECS];
    logic [CFG_W-1:0]       tuning [8];
    t_filt_out              filtered_q [$];
    int                     err_count = 0;
    int                     send_idle = 0;
    int                     recv_stall = 0;
    logic                   hold_req = 1'b0;
    logic                   row_typed = 1'b0;
    logic signed [SAMP_W-1:0] row_res = '0;

    // pass-through after reset: every result equals its sample
    t_stim_row reset_rows [8] = '{
        '{24'sh000000, 1'b0, 1'b0, 1'b1, 24'sh000000},
        '{24'sh7FFFFF, 1'b0, 1'b0, 1'b1, 24'sh7FFFFF},
        '{24'sh800000, 1'b0, 1'b0, 1'b1, 24'sh800000},
        '{24'sh000001, 1'b0, 1'b0, 1'b1, 24'sh000001},
        '{24'shFFFFFF, 1'b0, 1'b0, 1'b1, 24'shFFFFFF},
        '{24'sh555555, 1'b1, 1'b0, 1'b1, 24'sh555555},
        '{24'shAAAAAA, 1'b0, 1'b1, 1'b1, 24'shAAAAAA},
        '{24'sh123456, 1'b1, 1'b1, 1'b1, 24'sh123456}
    };

    // halving first section for rounding, extreme second section for saturation
    t_stim_row tuned_rows [12] = '{
        '{24'sh000003, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'shFFFFFD, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'sh000001, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'shFFFFFF, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'sh000002, 1'b0, 1'b1, 1'b0, 24'sh0},
        '{24'sh000000, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'sh7FFFFF, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'sh800000, 1'b0, 1'b0, 1'b0, 24'sh0},
        '{24'sh7FFFFF, 1'b1, 1'b0, 1'b0, 24'sh0},
        '{24'sh800000, 1'b1, 1'b1, 1'b0, 24'sh0},
        '{24'sh400000, 1'b0, 1'b1, 1'b0, 24'sh0},
        '{24'sh000000, 1'b1, 1'b1, 1'b0, 24'sh0}
    };

    biquad_cascade_iir_filter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #HALF_PERIOD i_clk = ~i_clk;
        end
    end

    initial begin
        #6ms;
        $display("** biquad_cascade_iir_filter_top: FAILED **");
        $finish;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint coef20(input logic [CFG_W-1:0] r, input int k);
        logic signed [COEF_W-1:0] f;
        f = r[COEF_W*k +: COEF_W];
        return f;
    endfunction

    function automatic longint coef24(input logic [CFG_W-1:0] r, input int k);
        logic signed [DEN_W-1:0] f;
        f = r[DEN_W*k +: DEN_W];
        return f;
    endfunction

    // one sample through the cascade, updating the model delay line
    function automatic logic signed [SAMP_W-1:0] cascade_filter(
        input logic signed [SAMP_W-1:0] smp, input logic prm);
        longint           x;
        longint           y;
        longint           acc;
        logic [CFG_W-1:0] num;
        logic [CFG_W-1:0] den;
        logic [CFG_W-1:0] seed;
        x = smp;
        if (prm) begin
            for (int i = 0; i < 2 * MAX_SECS; i++) begin
                seed = (i < MAX_SECS) ? model_reg[REG_PRIME_LO] : model_reg[REG_PRIME_HI];
                delay[i] = clip(coef20(seed, i % MAX_SECS) * (x <<< B_ALIGN),
                                STATE_MIN, STATE_MAX);
            end
        end
        for (int s = 0; s < SECTIONS; s++) begin
            num = model_reg[REG_SEC0_NUM + 2 * s];
            den = model_reg[REG_SEC0_DEN + 2 * s];
            acc = coef20(num, 0) * (x <<< B_ALIGN) + delay[2 * s];
            y = clip((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, SMP_MIN, SMP_MAX);
            delay[2 * s] = clip(coef20(num, 1) * (x <<< B_ALIGN) - coef24(den, 0) * y
                                + delay[2 * s + 1], STATE_MIN, STATE_MAX);
            delay[2 * s + 1] = clip(coef20(num, 2) * (x <<< B_ALIGN) - coef24(den, 1) * y,
                                    STATE_MIN, STATE_MAX);
            x = y;
        end
        return SAMP_W'(x);
    endfunction

    function automatic logic signed [SAMP_W-1:0] pick_sample(input logic signed [SAMP_W-1:0] prev);
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            d = $urandom_range(0, 8192);
            return SAMP_W'(clip(longint'(prev) + d - 4096, SMP_MIN, SMP_MAX));
        end else if (r < 80) begin
            return SAMP_W'($urandom);
        end else if (r < 90) begin
            d = $urandom_range(0, 32);
            return SAMP_W'(d - 16);
        end
        case ($urandom_range(0, 4))
            0:       return SAMP_W'(SMP_MAX);
            1:       return SAMP_W'(SMP_MIN);
            2:       return '0;
            3:       return SAMP_W'(1);
            default: return '1;
        endcase
    endfunction

    always @(posedge i_clk) begin : track
        t_filt_out                want;
        logic signed [SAMP_W-1:0] got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SEC0_DEN, REG_SEC1_DEN, REG_SEC2_DEN: begin
                        model_reg[i_cfg_index] = CFG_W'(i_cfg_data[DEN_REG_W-1:0]);
                    end
                    default: begin
                        model_reg[i_cfg_index] = i_cfg_data;
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want.filtered = cascade_filter(s_axis_tdata[SAMP_W-1:0], s_axis_tuser);
                want.last = s_axis_tlast;
                if (row_typed) begin
                    want.filtered = row_res;
                end
                filtered_q = {filtered_q, want};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[SAMP_W-1:0];
                if (filtered_q.size() == 0) begin
                    $error("unexpected result item: filtered %0d, last %0b", got, m_axis_tlast);
                    err_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (got !== want.filtered) begin
                        $error("filtered mismatch: expected %0d, actual %0d", want.filtered, got);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("result_last mismatch: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin : sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
            end
        end
    end

    task automatic offer(input t_stim_row r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'($unsigned(r.smp));
        s_axis_tuser  <= r.prm;
        s_axis_tlast  <= r.lst;
        row_typed = r.typed;
        row_res   = r.res;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic program_tuning();
        for (int i = 0; i < 8; i++) begin
            write_reg(CFG_IDX_W'(i), tuning[i]);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, let every result come back, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_tuning(input t_tune_kind kind);
        logic signed [COEF_W-1:0] b [3];
        int                       a1;
        int                       a2;
        int                       v;
        case (kind)
            TUNE_ZERO: begin
                for (int i = 0; i < 8; i++) tuning[i] = '0;
            end
            TUNE_ONES: begin
                for (int i = 0; i < 8; i++) tuning[i] = '1;
            end
            TUNE_NOISE: begin
                for (int i = 0; i < 8; i++) tuning[i] = CFG_W'({$urandom, $urandom});
            end
            default: begin
                // poles kept inside the unit circle
                for (int s = 0; s < MAX_SECS; s++) begin
                    for (int k = 0; k < 3; k++) begin
                        v = $urandom_range(0, 2 * ONE_Q17);
                        b[k] = COEF_W'(v - ONE_Q17);
                    end
                    a2 = $urandom_range(0, (ONE_Q21 / 10) * 9);
                    a1 = $urandom_range(0, ((ONE_Q21 + a2) / 10) * 9);
                    if ($urandom_range(0, 1)) begin
                        a1 = -a1;
                    end
                    tuning[REG_SEC0_NUM + 2 * s] = {b[2], b[1], b[0]};
                    tuning[REG_SEC0_DEN + 2 * s] = {PAD_W'($urandom), DEN_W'(a2), DEN_W'(a1)};
                end
                for (int k = 0; k < 3; k++) begin
                    v = $urandom_range(0, 2 * ONE_Q17);
                    b[k] = COEF_W'(v - ONE_Q17);
                end
                tuning[REG_PRIME_LO] = {b[2], b[1], b[0]};
                for (int k = 0; k < 3; k++) begin
                    v = $urandom_range(0, 2 * ONE_Q17);
                    b[k] = COEF_W'(v - ONE_Q17);
                end
                tuning[REG_PRIME_HI] = {b[2], b[1], b[0]};
            end
        endcase
    endtask

    initial begin : stimulus
        t_stim_row                row;
        t_tune_kind               kind;
        logic signed [SAMP_W-1:0] walk;
        int                       left;
        int                       flen;
        logic                     primed;
        logic                     noisy;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        walk          = '0;
        for (int i = 0; i < 8; i++) model_reg[i] = '0;
        model_reg[REG_SEC0_NUM] = NUM_RESET;
        model_reg[REG_SEC1_NUM] = NUM_RESET;
        model_reg[REG_SEC2_NUM] = NUM_RESET;
        for (int i = 0; i < 2 * MAX_SECS; i++) delay[i] = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (reset_rows[i]) offer(reset_rows[i]);
        settle();

        tuning[REG_SEC0_NUM] = {20'h00000, 20'h00000, 20'h10000};
        tuning[REG_SEC0_DEN] = {12'hFFF, 24'h000000, 24'h000000};
        tuning[REG_SEC1_NUM] = {20'h7FFFF, 20'h80000, 20'h7FFFF};
        tuning[REG_SEC1_DEN] = {12'hABC, 24'h800000, 24'h7FFFFF};
        tuning[REG_SEC2_NUM] = {20'h00000, 20'h00000, 20'h20000};
        tuning[REG_SEC2_DEN] = {12'h000, 24'h080000, 24'hF00000};
        tuning[REG_PRIME_LO] = {20'h7FFFF, 20'h7FFFF, 20'h7FFFF};
        tuning[REG_PRIME_HI] = {20'h80000, 20'h80000, 20'h80000};
        program_tuning();
        foreach (tuned_rows[i]) offer(tuned_rows[i]);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 48; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 15; recv_stall = 15; end
            endcase
            case (phase)
                1:       kind = TUNE_NOISE;
                3:       kind = TUNE_ZERO;
                5:       kind = TUNE_ONES;
                default: kind = TUNE_STABLE;
            endcase
            fill_tuning(kind);
            program_tuning();
            if (phase == PHASES - 1) begin
                // long output stall with the input kept busy
                send_idle = 0;
                recv_stall = 0;
                hold_req = 1'b1;
            end
            left = PHASE_ITEMS;
            while (left > 0) begin
                flen = $urandom_range(1, 48);
                if (flen > left) begin
                    flen = left;
                end
                primed = ($urandom_range(0, 9) < 8);
                for (int n = 0; n < flen; n++) begin
                    noisy     = ($urandom_range(0, 9) == 0);
                    walk      = pick_sample(walk);
                    row.smp   = walk;
                    row.prm   = ((n == 0) && primed) || (noisy && $urandom_range(0, 1));
                    row.lst   = (n == flen - 1) || (noisy && $urandom_range(0, 1));
                    row.typed = 1'b0;
                    row.res   = '0;
                    offer(row);
                end
                left -= flen;
            end
            settle();
        end

        if (err_count == 0) begin
            $display("** biquad_cascade_iir_filter_top: PASSED **");
        end else begin
            $display("** biquad_cascade_iir_filter_top: FAILED **");
        end
        $finish;
    end

endmodule
